/* src/lfu_pkg.sv */
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU key-value store.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 5;
  localparam int KEY_W       = 32;
  localparam int DATA_W      = 32;
  localparam int USE_W       = 16;
  localparam int STAMP_W     = 32;
  localparam int ENTRY_W     = KEY_W + DATA_W + USE_W + STAMP_W;
  localparam logic [USE_W-1:0] USE_MAX = '1;
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic                     command;
    logic signed [KEY_W-1:0]  key;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                     found;
    logic signed [DATA_W-1:0] read_value;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  data;
    logic [USE_W-1:0]   use_count;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_WRITE
  } state_t;

endpackage

/* src/lfu_ram.sv */
// ----------------------------------------------------------------------------
// lfu_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/lfu_cache_store.sv */
// ----------------------------------------------------------------------------
// lfu_cache_store
// Key-value store with least-frequently-used replacement, oldest stamp breaks
// ties. Entries live in one RAM; each transaction scans every slot.
// ----------------------------------------------------------------------------
//  channel   signals                        direction
//  request   start, busy, req               in  (accepted: start & !busy)
//  result    rsp_valid, rsp                 out (one-cycle strobe)
//  config    capacity_we, capacity_wdata    in
//
//  A transaction keeps busy high through ST_SCAN, ST_LAST and ST_WRITE: one RAM
//  read per slot in ST_SCAN, the last read checked in ST_LAST, one write-back in
//  ST_WRITE. The result strobes in the first cycle after write-back,
//  when busy is already low. Reset clears valid bits, occupancy, stamp counter
//  and capacity (to 16). The receiver cannot stall.
module lfu_cache_store (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  lfu_pkg::req_t                       req,
  output logic                                rsp_valid,
  output lfu_pkg::rsp_t                       rsp,
  input  logic                                capacity_we,
  input  logic [lfu_pkg::CAP_W-1:0]           capacity_wdata
);

  lfu_pkg::state_t state, state_next;
  logic [lfu_pkg::CAP_W-1:0]   capacity;
  logic [lfu_pkg::MAX_ENTRIES-1:0] valid;
  logic [lfu_pkg::CNT_W-1:0]   occupied;
  logic [lfu_pkg::STAMP_W-1:0] stamp_counter;
  lfu_pkg::req_t               cur;
  logic [lfu_pkg::IDX_W-1:0]   raddr;
  logic [lfu_pkg::IDX_W-1:0]   chk;
  logic                        hit;
  logic [lfu_pkg::IDX_W-1:0]   hit_idx;
  lfu_pkg::entry_t             hit_ent;
  logic                        vic_ok;
  logic [lfu_pkg::IDX_W-1:0]   vic_idx;
  logic [lfu_pkg::USE_W-1:0]   vic_use;
  logic [lfu_pkg::STAMP_W-1:0] vic_stamp;
  lfu_pkg::entry_t             rdata;
  logic                        we;
  logic [lfu_pkg::IDX_W-1:0]   waddr;
  lfu_pkg::entry_t             wdata;
  logic                        free_ok;
  logic [lfu_pkg::IDX_W-1:0]   free_idx;
  logic [lfu_pkg::CNT_W-1:0]   cap_eff;
  logic [lfu_pkg::STAMP_W-1:0] stamp_inc;
  logic                        do_ins;
  logic                        do_upd;
  logic                        better;

  lfu_ram #(
    .WIDTH(lfu_pkg::ENTRY_W),
    .DEPTH(lfu_pkg::MAX_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = lfu_pkg::MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_ok  = 1'b1;
        free_idx = lfu_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (capacity > lfu_pkg::CAP_W'(lfu_pkg::MAX_ENTRIES)) begin
      cap_eff = lfu_pkg::CNT_W'(lfu_pkg::MAX_ENTRIES);
    end else begin
      cap_eff = lfu_pkg::CNT_W'(capacity);
    end
  end

  assign stamp_inc = stamp_counter + 1'b1;
  assign better = !vic_ok || rdata.use_count < vic_use ||
                  (rdata.use_count == vic_use && rdata.stamp < vic_stamp);

  always_comb begin
    state_next = state;
    busy       = state != lfu_pkg::ST_IDLE;
    case (state)
      lfu_pkg::ST_IDLE:  if (start) state_next = lfu_pkg::ST_SCAN;
      lfu_pkg::ST_SCAN:  if (raddr == lfu_pkg::IDX_W'(lfu_pkg::MAX_ENTRIES - 1))
                           state_next = lfu_pkg::ST_LAST;
      lfu_pkg::ST_LAST:  state_next = lfu_pkg::ST_WRITE;
      lfu_pkg::ST_WRITE: state_next = lfu_pkg::ST_IDLE;
      default:           state_next = lfu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    do_upd = (state == lfu_pkg::ST_WRITE) && hit &&
             (cur.command == lfu_pkg::CMD_GET || cap_eff != '0);
    do_ins = (state == lfu_pkg::ST_WRITE) && !hit &&
             cur.command == lfu_pkg::CMD_PUT && cap_eff != '0 &&
             ((occupied >= cap_eff) ? vic_ok : free_ok);
    we    = do_upd || do_ins;
    waddr = hit ? hit_idx : ((occupied >= cap_eff) ? vic_idx : free_idx);
    wdata = hit_ent;
    if (do_upd) begin
      wdata.stamp = stamp_inc;
      if (hit_ent.use_count != lfu_pkg::USE_MAX)
        wdata.use_count = hit_ent.use_count + 1'b1;
      if (cur.command == lfu_pkg::CMD_PUT) wdata.data = cur.value;
    end else begin
      wdata.key       = cur.key;
      wdata.data      = cur.value;
      wdata.use_count = lfu_pkg::USE_W'(1);
      wdata.stamp     = stamp_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= lfu_pkg::ST_IDLE;
      capacity      <= lfu_pkg::CAP_W'(16);
      valid         <= '0;
      occupied      <= '0;
      stamp_counter <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= 1'b0;
      if (capacity_we) capacity <= capacity_wdata;
      if (state == lfu_pkg::ST_WRITE) rsp_valid <= 1'b1;
      if (we) stamp_counter <= stamp_inc;
      if (do_ins) begin
        valid[waddr] <= 1'b1;
        if (occupied < cap_eff) occupied <= occupied + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      lfu_pkg::ST_IDLE: begin
        cur    <= req;
        raddr  <= '0;
        chk    <= '0;
        hit    <= 1'b0;
        vic_ok <= 1'b0;
      end
      lfu_pkg::ST_SCAN, lfu_pkg::ST_LAST: begin
        if (state == lfu_pkg::ST_SCAN) raddr <= raddr + 1'b1;
        if (state == lfu_pkg::ST_LAST || raddr != '0) begin
          chk <= chk + 1'b1;
          if (valid[chk]) begin
            if (!hit && rdata.key == cur.key) begin
              hit     <= 1'b1;
              hit_idx <= chk;
              hit_ent <= rdata;
            end
            if (better) begin
              vic_ok    <= 1'b1;
              vic_idx   <= chk;
              vic_use   <= rdata.use_count;
              vic_stamp <= rdata.stamp;
            end
          end
        end
      end
      lfu_pkg::ST_WRITE: begin
        rsp.found <= hit;
        if (cur.command == lfu_pkg::CMD_PUT) rsp.read_value <= '0;
        else if (hit) rsp.read_value <= hit_ent.data;
        else rsp.read_value <= lfu_pkg::MISS_VALUE;
      end
      default: ;
    endcase
  end

endmodule
